// File: design/mtp_pkg.sv
`default_nettype none
package mtp_pkg;

   localparam int NumPatches       = 128;
   localparam int NumChannels      = 16;
   localparam int MaxQuantityBytes = 4;
   localparam int QueueDepth       = 4;
   localparam int PatchWidth       = $clog2(NumPatches);
   localparam int ChanWidth        = $clog2(NumChannels);
   localparam int EntryWidth       = 2 * PatchWidth + 1;

   localparam logic [7:0] ST_META   = 8'hFF;
   localparam logic [7:0] ST_SYSEX  = 8'hF0;
   localparam logic [7:0] ST_ESCAPE = 8'hF7;
   localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
   localparam logic [3:0] CMD_AFTERTOUCH = 4'hA;
   localparam logic [3:0] CMD_PROGRAM    = 4'hC;
   localparam logic [3:0] CMD_PRESSURE   = 4'hD;
   localparam logic [3:0] CMD_PITCH      = 4'hE;
   localparam logic [7:0] MT_TEXT_FIRST  = 8'h01;
   localparam logic [7:0] MT_TEXT_LAST   = 8'h07;
   localparam logic [7:0] MT_TEMPO       = 8'h51;
   localparam logic [7:0] MT_TIMESIG     = 8'h58;

   typedef enum logic [1:0] {
      MODE_TRACK = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_CHAN    = 3'd0,
      KIND_META    = 3'd1,
      KIND_SYSEX   = 3'd2,
      KIND_TEXT    = 3'd3,
      KIND_BADLEN  = 3'd4,
      KIND_UNKNOWN = 3'd5,
      KIND_PATCH   = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      PH_DELTA  = 4'd0,
      PH_STATUS = 4'd1,
      PH_CHAN   = 4'd2,
      PH_MTYPE  = 4'd3,
      PH_LEN    = 4'd4,
      PH_MDATA  = 4'd5,
      PH_SDATA  = 4'd6
   } phase_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_NOTE  = 3'd1,
      OP_PATCH = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RS_NEED = 2'd0,
      RS_WAIT = 2'd1,
      RS_DONE = 2'd2
   } rstate_type;

   typedef logic [3:0][7:0] cap_type;

   typedef struct packed {
      kind_type     kind;
      logic [27:0]  delta_ticks;
      logic [7:0]   command_code;
      logic [3:0]   channel;
      logic [7:0]   value_a;
      logic [7:0]   value_b;
      logic [7:0]   value_c;
      logic [7:0]   value_d;
      logic [23:0]  tempo;
      logic         last_text_byte;
      logic         patch_used;
   } rec_type;

   typedef struct packed {
      logic                  r0_v;
      rec_type               r0;
      logic                  r1_v;
      rec_type               r1;
      op_type                op;
      logic [PatchWidth-1:0] patch;
      logic [6:0]            note;
   } entry_type;

   // Build the meta event report from the captured payload
   function automatic rec_type meta_rec(logic [27:0] dt, logic [7:0] mtype, cap_type cap);
      rec_type r;
      r = '0;
      r.kind         = KIND_META;
      r.delta_ticks  = dt;
      r.command_code = mtype;
      if (mtype == MT_TEMPO) begin
         r.tempo = {cap[0], cap[1], cap[2]};
      end else if (mtype == MT_TIMESIG) begin
         r.value_a = cap[0];
         r.value_b = cap[1];
         r.value_c = cap[2];
         r.value_d = cap[3];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/mtp_if.sv
`default_nettype none
interface mtp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   logic [6:0] patch_index;
   modport source (output valid, mode, data_byte, patch_index, input ready);
   modport sink (input valid, mode, data_byte, patch_index, output ready);
endinterface

interface mtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [27:0] delta_ticks;
   logic [7:0]  command_code;
   logic [3:0]  channel;
   logic [7:0]  value_a;
   logic [7:0]  value_b;
   logic [7:0]  value_c;
   logic [7:0]  value_d;
   logic [23:0] tempo;
   logic        last_text_byte;
   logic        patch_used;
   modport source (output valid, result_kind, delta_ticks, command_code, channel, value_a,
                   value_b, value_c, value_d, tempo, last_text_byte, patch_used,
                   input ready);
   modport sink (input valid, result_kind, delta_ticks, command_code, channel, value_a,
                 value_b, value_c, value_d, tempo, last_text_byte, patch_used,
                 output ready);
endinterface
`default_nettype wire

// File: design/mtp_ram.sv
`default_nettype none
module mtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: design/mtp_fifo.sv
`default_nettype none
module mtp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mtp_pkg::entry_type push_entry,
   input  wire logic               pop,
   output mtp_pkg::entry_type      head,
   output logic                    empty,
   output logic                    full
);
   import mtp_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);

   entry_type           mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0]   cnt_ff, cnt_in;

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PtrWidth+1)'(QueueDepth));

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

// File: design/mtp_front.sv
`default_nettype none
module mtp_front #(
   parameter int MAX_QUANTITY_BYTES = mtp_pkg::MaxQuantityBytes
) (
   input  wire logic          clock,
   input  wire logic          reset,
   mtp_req_if.sink            req_if,
   input  wire logic          full,
   output logic               push,
   output mtp_pkg::entry_type push_entry
);
   import mtp_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [27:0]     acc_ff, acc_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [27:0]     delta_ff, delta_in;
   logic [7:0]      status_ff, status_in;
   logic [7:0]      mtype_ff, mtype_in;
   logic [27:0]     rem_ff, rem_in;
   cap_type         cap_ff, cap_in;
   logic [PatchWidth-1:0] map_ff [NumChannels];
   logic [PatchWidth-1:0] map_wdata;
   logic            map_we, map_clr;

   logic            accept, track;
   logic [7:0]      b;
   logic [27:0]     qacc;
   logic [2:0]      qcnt, cnt_cap;
   logic            qdone, qover, is_chan_status, is_text;
   logic [27:0]     rem_dec;
   cap_type         cap_next;
   logic [3:0]      cmd;
   logic [ChanWidth-1:0] ch;

   assign req_if.ready = !full;
   assign accept = req_if.valid && !full;
   assign track  = accept && (mode_type'(req_if.mode) == MODE_TRACK);
   assign b      = req_if.data_byte;
   assign cmd    = status_ff[7:4];
   assign ch     = status_ff[ChanWidth-1:0];

   // Shared quantity and capture arithmetic
   always_comb begin
      qacc    = {acc_ff[20:0], b[6:0]};
      qcnt    = cnt_ff + 3'd1;
      qdone   = !b[7];
      qover   = b[7] && (int'(qcnt) >= MAX_QUANTITY_BYTES);
      rem_dec = rem_ff - 28'd1;
      cap_next = cap_ff;
      cnt_cap  = cnt_ff;
      if (!cnt_ff[2]) begin
         cap_next[cnt_ff[1:0]] = b;
         cnt_cap = qcnt;
      end
      is_chan_status = b[7] && (b[7:4] <= CMD_PITCH);
      is_text = (mtype_ff >= MT_TEXT_FIRST) && (mtype_ff <= MT_TEXT_LAST);
   end

   // Next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (track) begin
         case (phase_ff)
            PH_STATUS: begin
               if (is_chan_status) phase_in = PH_CHAN;
               else if (b == ST_META) phase_in = PH_MTYPE;
               else if (b == ST_SYSEX || b == ST_ESCAPE) phase_in = PH_LEN;
               else phase_in = PH_DELTA;
            end
            PH_CHAN: phase_in = (rem_dec == '0) ? PH_DELTA : PH_CHAN;
            PH_MTYPE: phase_in = PH_LEN;
            PH_LEN: begin
               if (qover) phase_in = PH_DELTA;
               else if (!qdone) phase_in = PH_LEN;
               else if (qacc == '0) phase_in = PH_DELTA;
               else if (status_ff == ST_META) phase_in = PH_MDATA;
               else phase_in = PH_SDATA;
            end
            PH_MDATA: phase_in = (rem_dec == '0) ? PH_DELTA : PH_MDATA;
            PH_SDATA: phase_in = (rem_dec == '0) ? PH_DELTA : PH_SDATA;
            default: begin
               if (qover) phase_in = PH_DELTA;
               else if (qdone) phase_in = PH_STATUS;
               else phase_in = PH_DELTA;
            end
         endcase
      end
   end

   // Datapath updates and queue entries
   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      delta_in  = delta_ff;
      status_in = status_ff;
      mtype_in  = mtype_ff;
      rem_in    = rem_ff;
      cap_in    = cap_ff;
      map_we    = 1'b0;
      map_clr   = 1'b0;
      map_wdata = '0;
      push       = 1'b0;
      push_entry = '0;
      if (track) begin
         case (phase_ff)
            PH_STATUS: begin
               status_in = b;
               if (is_chan_status) begin
                  rem_in = (b[7:4] == CMD_PROGRAM || b[7:4] == CMD_PRESSURE) ? 28'd1 : 28'd2;
               end else if (!(b == ST_META || b == ST_SYSEX || b == ST_ESCAPE)) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_UNKNOWN;
                  push_entry.r0.delta_ticks = delta_ff;
                  push_entry.r0.command_code = b;
                  acc_in = '0;
                  cnt_in = '0;
               end
            end
            PH_CHAN: begin
               cap_in = cap_next;
               cnt_in = cnt_cap;
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_CHAN;
                  push_entry.r0.delta_ticks = delta_ff;
                  push_entry.r0.command_code = {cmd, 4'h0};
                  push_entry.r0.channel = status_ff[3:0];
                  push_entry.r0.value_a = cap_next[0];
                  if (!(cmd == CMD_PROGRAM || cmd == CMD_PRESSURE)) begin
                     push_entry.r0.value_b = cap_next[1];
                  end
                  if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_AFTERTOUCH) begin
                     push_entry.op    = OP_NOTE;
                     push_entry.patch = map_ff[ch];
                     push_entry.note  = cap_next[0][6:0];
                  end else if (cmd == CMD_PROGRAM) begin
                     push_entry.op    = OP_PATCH;
                     push_entry.patch = cap_next[0][PatchWidth-1:0];
                     map_we    = 1'b1;
                     map_wdata = cap_next[0][PatchWidth-1:0];
                  end
                  acc_in = '0;
                  cnt_in = '0;
               end
            end
            PH_MTYPE: mtype_in = b;
            PH_LEN: begin
               if (qover) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_BADLEN;
                  push_entry.r0.delta_ticks = delta_ff;
                  push_entry.r0.command_code = status_ff;
                  acc_in = '0;
                  cnt_in = '0;
               end else if (!qdone) begin
                  acc_in = qacc;
                  cnt_in = qcnt;
               end else begin
                  rem_in = qacc;
                  acc_in = '0;
                  cnt_in = '0;
                  if (qacc == '0) begin
                     push = 1'b1;
                     push_entry.r0_v = 1'b1;
                     if (status_ff == ST_META) begin
                        push_entry.r0 = meta_rec(delta_ff, mtype_ff, cap_ff);
                     end else begin
                        push_entry.r0.kind = KIND_SYSEX;
                        push_entry.r0.delta_ticks = delta_ff;
                        push_entry.r0.command_code = status_ff;
                     end
                  end
               end
            end
            PH_MDATA: begin
               cap_in = cap_next;
               cnt_in = cnt_cap;
               rem_in = rem_dec;
               if (is_text) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_TEXT;
                  push_entry.r0.delta_ticks = delta_ff;
                  push_entry.r0.command_code = mtype_ff;
                  push_entry.r0.value_a = b;
                  push_entry.r0.last_text_byte = (rem_dec == '0);
                  if (rem_dec == '0) begin
                     push_entry.r1_v = 1'b1;
                     push_entry.r1 = meta_rec(delta_ff, mtype_ff, cap_next);
                  end
               end else if (rem_dec == '0) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0 = meta_rec(delta_ff, mtype_ff, cap_next);
               end
               if (rem_dec == '0) begin
                  acc_in = '0;
                  cnt_in = '0;
               end
            end
            PH_SDATA: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_SYSEX;
                  push_entry.r0.delta_ticks = delta_ff;
                  push_entry.r0.command_code = status_ff;
                  acc_in = '0;
                  cnt_in = '0;
               end
            end
            default: begin
               if (qover) begin
                  push = 1'b1;
                  push_entry.r0_v = 1'b1;
                  push_entry.r0.kind = KIND_BADLEN;
                  acc_in = '0;
                  cnt_in = '0;
               end else if (qdone) begin
                  delta_in = qacc;
                  acc_in   = '0;
                  cnt_in   = '0;
                  cap_in   = '0;
               end else begin
                  acc_in = qacc;
                  cnt_in = qcnt;
               end
            end
         endcase
      end else if (accept) begin
         case (mode_type'(req_if.mode))
            MODE_READ: begin
               push = 1'b1;
               push_entry.r0_v = 1'b1;
               push_entry.r0.kind = KIND_PATCH;
               push_entry.op    = OP_READ;
               push_entry.patch = req_if.patch_index[PatchWidth-1:0];
            end
            MODE_CLEAR: begin
               push = 1'b1;
               push_entry.op = OP_CLEAR;
               map_clr = 1'b1;
            end
            default: push = 1'b0;
         endcase
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         delta_ff  <= '0;
         status_ff <= '0;
         mtype_ff  <= '0;
         rem_ff    <= '0;
         cap_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         delta_ff  <= delta_in;
         status_ff <= status_in;
         mtype_ff  <= mtype_in;
         rem_ff    <= rem_in;
         cap_ff    <= cap_in;
      end
   end

   // Channel to patch map
   always_ff @(posedge clock) begin
      for (int i = 0; i < NumChannels; i++) begin
         if (reset || map_clr) begin
            map_ff[i] <= '0;
         end else if (map_we && ch == ChanWidth'(i)) begin
            map_ff[i] <= map_wdata;
         end
      end
   end
endmodule
`default_nettype wire

// File: design/mtp_back.sv
`default_nettype none
module mtp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mtp_pkg::entry_type head,
   input  wire logic               empty,
   output logic                    pop,
   mtp_rsp_if.source               rsp_if
);
   import mtp_pkg::*;

   entry_type  cur_ff, cur_in;
   logic       cur_v_ff, cur_v_in;
   logic       second_ff, second_in;
   rstate_type rs_ff, rs_in;
   logic       out_v_ff, out_v_in;
   rec_type    out_ff, out_in;
   logic [NumPatches-1:0] pvalid_ff, pvalid_in;

   logic                  ram_we;
   logic [EntryWidth-1:0] ram_wdata, ram_rdata, ent;
   logic [6:0]            low, high, nlow, nhigh;
   logic                  used;
   logic                  out_free, emit, fire, last, load;

   mtp_ram #(.WIDTH(EntryWidth), .DEPTH(NumPatches)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cur_ff.patch),
      .wdata (ram_wdata),
      .raddr (cur_ff.patch),
      .rdata (ram_rdata)
   );

   // Entry as seen through its valid bit
   always_comb begin
      ent   = pvalid_ff[cur_ff.patch] ? ram_rdata : '0;
      low   = ent[EntryWidth-1 -: 7];
      high  = ent[7:1];
      used  = ent[0];
      nlow  = (cur_ff.note < low || low == '0) ? cur_ff.note : low;
      nhigh = (cur_ff.note > high) ? cur_ff.note : high;
   end

   // Next read state
   always_comb begin
      rs_in = rs_ff;
      case (rs_ff)
         RS_NEED: rs_in = RS_WAIT;
         RS_WAIT: rs_in = RS_DONE;
         default: rs_in = RS_DONE;
      endcase
      if (load) begin
         rs_in = (head.op == OP_NOTE || head.op == OP_PATCH || head.op == OP_READ) ?
                 RS_NEED : RS_DONE;
      end
   end

   // Table update, emission and queue pop
   always_comb begin
      out_free  = !out_v_ff || rsp_if.ready;
      emit      = second_ff || cur_ff.r0_v;
      fire      = cur_v_ff && rs_ff == RS_DONE && (!emit || out_free);
      last      = second_ff || !cur_ff.r1_v;
      load      = (!cur_v_ff || (fire && last)) && !empty;
      pop       = load;
      cur_in    = cur_ff;
      cur_v_in  = cur_v_ff;
      second_in = second_ff;
      out_v_in  = out_v_ff && !rsp_if.ready;
      out_in    = out_ff;
      pvalid_in = pvalid_ff;
      ram_we    = 1'b0;
      ram_wdata = '0;
      if (cur_v_ff && rs_ff == RS_WAIT) begin
         case (cur_ff.op)
            OP_NOTE: begin
               ram_we    = 1'b1;
               ram_wdata = {nlow, nhigh, used};
            end
            OP_PATCH: begin
               ram_we    = 1'b1;
               ram_wdata = {low, high, 1'b1};
            end
            OP_READ: begin
               cur_in.r0.value_a    = {1'b0, low};
               cur_in.r0.value_b    = {1'b0, high};
               cur_in.r0.patch_used = used;
            end
            default: ram_we = 1'b0;
         endcase
         if (ram_we) begin
            pvalid_in[cur_ff.patch] = 1'b1;
         end
      end
      if (fire) begin
         if (emit) begin
            out_v_in = 1'b1;
            out_in   = second_ff ? cur_ff.r1 : cur_ff.r0;
         end
         if (last) begin
            cur_v_in  = 1'b0;
            second_in = 1'b0;
            if (cur_ff.op == OP_CLEAR) begin
               pvalid_in = '0;
            end
         end else begin
            second_in = 1'b1;
         end
      end
      if (load) begin
         cur_in   = head;
         cur_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff  <= 1'b0;
         second_ff <= 1'b0;
         rs_ff     <= RS_DONE;
         out_v_ff  <= 1'b0;
         pvalid_ff <= '0;
      end else begin
         cur_v_ff  <= cur_v_in;
         second_ff <= second_in;
         rs_ff     <= rs_in;
         out_v_ff  <= out_v_in;
         pvalid_ff <= pvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_if.valid          = out_v_ff;
   assign rsp_if.result_kind    = out_ff.kind;
   assign rsp_if.delta_ticks    = out_ff.delta_ticks;
   assign rsp_if.command_code   = out_ff.command_code;
   assign rsp_if.channel        = out_ff.channel;
   assign rsp_if.value_a        = out_ff.value_a;
   assign rsp_if.value_b        = out_ff.value_b;
   assign rsp_if.value_c        = out_ff.value_c;
   assign rsp_if.value_d        = out_ff.value_d;
   assign rsp_if.tempo          = out_ff.tempo;
   assign rsp_if.last_text_byte = out_ff.last_text_byte;
   assign rsp_if.patch_used     = out_ff.patch_used;
endmodule
`default_nettype wire

// File: design/midi_track_event_parser.sv
// MIDI track event parser.
// req_if takes one request per cycle while the queue has room: mode track
// byte, patch entry read, or patch table clear. rsp_if returns event
// reports, text bytes, errors and patch entries in request order; a request
// gives zero, one or two results. A front parser decodes delta times,
// lengths and status bytes at one byte per cycle while the queue has room
// and posts work to a four-entry queue; the back end performs patch table
// accesses and drives a registered response. A note or patch change does a
// read-modify-write of the patch table RAM and a patch read reads it; each
// steps the back end through RS_NEED, RS_WAIT and RS_DONE.
// Throughput: one byte per cycle while the queue has room; the final byte of
// a text event gives two responses.
// Reset clears the parse state, the channel map and the patch entry valid
// bits at once; no clearing pass is needed.
// While rsp_if stalls, results wait in the output register and the queue;
// req_if.ready drops only when the queue is full.
`default_nettype none
module midi_track_event_parser #(
   parameter int MAX_QUANTITY_BYTES = mtp_pkg::MaxQuantityBytes
) (
   input wire logic  clock,
   input wire logic  reset,
   mtp_req_if.sink   req_if,
   mtp_rsp_if.source rsp_if
);
   import mtp_pkg::*;

   logic      q_push, q_pop, q_empty, q_full;
   entry_type q_in, q_head;

   mtp_front #(.MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .full       (q_full),
      .push       (q_push),
      .push_entry (q_in)
   );

   mtp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   mtp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .empty  (q_empty),
      .pop    (q_pop),
      .rsp_if (rsp_if)
   );

   // Queue is never written when full nor read when empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue underflow");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid) else $error("response after reset");
endmodule
`default_nettype wire

// File: tb/mtp_tb_if.sv
`default_nettype none
// Channel interfaces are supplied by the design; this file holds the
// testbench-side helper types only.
package mtp_tb_pkg;
   import mtp_pkg::*;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] data_byte;
      logic [6:0] patch_index;
   } request_type;
endpackage
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
   import mtp_pkg::*;
   import mtp_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtp_req_if req_if ();
   mtp_rsp_if rsp_if ();

   midi_track_event_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #4 clock = ~clock;

   // Parser state mirrored in the testbench
   phase_type   phase_q;
   logic [27:0] accum_q;
   int          qcount_q;
   logic [27:0] delta_q;
   logic [7:0]  status_q;
   logic [7:0]  mtype_q;
   logic [27:0] remain_q;
   logic [7:0]  cap_q [4];
   logic [6:0]  chan_map [16];
   logic [6:0]  low_note [128];
   logic [6:0]  high_note [128];
   logic        used_flag [128];

   rec_type expected_results [$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      errors;
   int      results_seen;
   int      requests_sent;

   function automatic rec_type blank_rec(kind_type k, logic [27:0] dt, logic [7:0] code);
      rec_type r;
      r = '0;
      r.kind = k;
      r.delta_ticks = dt;
      r.command_code = code;
      return r;
   endfunction

   function automatic void restart_parse();
      phase_q = PH_DELTA;
      accum_q = '0;
      qcount_q = 0;
   endfunction

   function automatic void clear_patch_tables();
      for (int i = 0; i < 16; i++) chan_map[i] = '0;
      for (int i = 0; i < 128; i++) begin
         low_note[i] = '0;
         high_note[i] = '0;
         used_flag[i] = 1'b0;
      end
   endfunction

   function automatic void capture_byte(logic [7:0] b);
      if (qcount_q < 4) begin
         cap_q[qcount_q] = b;
         qcount_q++;
      end
   endfunction

   // Returns 1 when complete, -1 when overlong, 0 otherwise
   function automatic int quantity_step(logic [7:0] b);
      accum_q = {accum_q[20:0], b[6:0]};
      qcount_q++;
      if (!b[7]) return 1;
      if (qcount_q >= MaxQuantityBytes) return -1;
      return 0;
   endfunction

   function automatic void push_meta_report();
      rec_type r;
      r = blank_rec(KIND_META, delta_q, mtype_q);
      if (mtype_q == MT_TEMPO) begin
         r.tempo = {cap_q[0], cap_q[1], cap_q[2]};
      end else if (mtype_q == MT_TIMESIG) begin
         r.value_a = cap_q[0];
         r.value_b = cap_q[1];
         r.value_c = cap_q[2];
         r.value_d = cap_q[3];
      end
      expected_results.push_back(r);
      restart_parse();
   endfunction

   function automatic void finish_channel_event();
      rec_type    r;
      logic [3:0] cmd;
      logic [3:0] ch;
      logic [6:0] p;
      logic [6:0] note;
      cmd = status_q[7:4];
      ch = status_q[3:0];
      r = blank_rec(KIND_CHAN, delta_q, {cmd, 4'h0});
      r.channel = ch;
      r.value_a = cap_q[0];
      r.value_b = (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) ? 8'h00 : cap_q[1];
      if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_AFTERTOUCH) begin
         p = chan_map[ch];
         note = cap_q[0][6:0];
         if (note < low_note[p] || low_note[p] == 0) low_note[p] = note;
         if (note > high_note[p]) high_note[p] = note;
      end else if (cmd == CMD_PROGRAM) begin
         p = cap_q[0][6:0];
         used_flag[p] = 1'b1;
         chan_map[ch] = p;
      end
      expected_results.push_back(r);
      restart_parse();
   endfunction

   function automatic void predict_track_byte(logic [7:0] b);
      int      q;
      rec_type r;
      case (phase_q)
         PH_STATUS: begin
            status_q = b;
            if (b[7] && b[7:4] <= 4'hE) begin
               remain_q = (b[7:4] == CMD_PROGRAM || b[7:4] == CMD_PRESSURE) ? 28'd1 : 28'd2;
               phase_q = PH_CHAN;
            end else if (b == ST_META) begin
               phase_q = PH_MTYPE;
            end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
               phase_q = PH_LEN;
            end else begin
               expected_results.push_back(blank_rec(KIND_UNKNOWN, delta_q, b));
               restart_parse();
            end
         end
         PH_CHAN: begin
            capture_byte(b);
            remain_q = remain_q - 28'd1;
            if (remain_q == 0) finish_channel_event();
         end
         PH_MTYPE: begin
            mtype_q = b;
            phase_q = PH_LEN;
         end
         PH_LEN: begin
            q = quantity_step(b);
            if (q < 0) begin
               expected_results.push_back(blank_rec(KIND_BADLEN, delta_q, status_q));
               restart_parse();
            end else if (q > 0) begin
               remain_q = accum_q;
               accum_q = '0;
               qcount_q = 0;
               if (status_q == ST_META) begin
                  if (remain_q == 0) push_meta_report();
                  else phase_q = PH_MDATA;
               end else if (remain_q == 0) begin
                  expected_results.push_back(blank_rec(KIND_SYSEX, delta_q, status_q));
                  restart_parse();
               end else begin
                  phase_q = PH_SDATA;
               end
            end
         end
         PH_MDATA: begin
            capture_byte(b);
            remain_q = remain_q - 28'd1;
            if (mtype_q >= MT_TEXT_FIRST && mtype_q <= MT_TEXT_LAST) begin
               r = blank_rec(KIND_TEXT, delta_q, mtype_q);
               r.value_a = b;
               r.last_text_byte = (remain_q == 0);
               expected_results.push_back(r);
            end
            if (remain_q == 0) push_meta_report();
         end
         PH_SDATA: begin
            remain_q = remain_q - 28'd1;
            if (remain_q == 0) begin
               expected_results.push_back(blank_rec(KIND_SYSEX, delta_q, status_q));
               restart_parse();
            end
         end
         default: begin
            phase_q = PH_DELTA;
            q = quantity_step(b);
            if (q < 0) begin
               expected_results.push_back(blank_rec(KIND_BADLEN, '0, '0));
               restart_parse();
            end else if (q > 0) begin
               delta_q = accum_q;
               accum_q = '0;
               qcount_q = 0;
               for (int i = 0; i < 4; i++) cap_q[i] = '0;
               phase_q = PH_STATUS;
            end
         end
      endcase
   endfunction

   function automatic void predict_request(request_type rq);
      rec_type r;
      if (rq.mode == MODE_TRACK) begin
         predict_track_byte(rq.data_byte);
      end else if (rq.mode == MODE_READ) begin
         r = blank_rec(KIND_PATCH, '0, '0);
         r.value_a = {1'b0, low_note[rq.patch_index]};
         r.value_b = {1'b0, high_note[rq.patch_index]};
         r.patch_used = used_flag[rq.patch_index];
         expected_results.push_back(r);
      end else if (rq.mode == MODE_CLEAR) begin
         clear_patch_tables();
      end
   endfunction

   // Send one request, predicting its results on acceptance
   task automatic send_request(request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= rq.mode;
      req_if.data_byte <= rq.data_byte;
      req_if.patch_index <= rq.patch_index;
      do @(posedge clock); while (!req_if.ready);
      predict_request(rq);
      requests_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      request_type rq;
      rq.mode = MODE_TRACK;
      rq.data_byte = b;
      rq.patch_index = 7'($urandom);
      send_request(rq);
   endtask

   task automatic send_mode(mode_type m, logic [6:0] idx);
      request_type rq;
      rq.mode = m;
      rq.data_byte = 8'($urandom);
      rq.patch_index = idx;
      send_request(rq);
   endtask

   // Variable-length quantity, most significant group first
   task automatic send_quantity(logic [27:0] v);
      int n;
      n = 1;
      while (n < 4 && (v >> (7 * n)) != 0) n++;
      for (int i = n - 1; i >= 0; i--) send_byte({(i != 0), 7'(v >> (7 * i))});
   endtask

   task automatic random_delta();
      case ($urandom_range(3))
         0: send_quantity(28'd0);
         1: send_quantity(28'($urandom_range(127)));
         2: send_quantity(28'($urandom_range(16383)));
         default: send_quantity(28'($urandom));
      endcase
   endtask

   // Response side: random back-pressure and in-order comparison
   always @(posedge clock) begin
      rec_type e;
      rec_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{kind_type'(rsp_if.result_kind), rsp_if.delta_ticks, rsp_if.command_code,
                    rsp_if.channel, rsp_if.value_a, rsp_if.value_b, rsp_if.value_c,
                    rsp_if.value_d, rsp_if.tempo, rsp_if.last_text_byte, rsp_if.patch_used};
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", got);
            end else begin
               e = expected_results.pop_front();
               if (got !== e) begin
                  errors++;
                  if (errors <= 10) $display("result %0d: expected %p, got %p",
                                             results_seen, e, got);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic test_channel_events();
      // each channel command, extreme notes and channels, patch tracking
      send_byte(8'h00); send_byte(8'hC3); send_byte(8'h7F);
      send_byte(8'h00); send_byte(8'h93); send_byte(8'h00); send_byte(8'h7F);
      send_byte(8'h00); send_byte(8'h83); send_byte(8'hFF); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'hAF); send_byte(8'h40); send_byte(8'h40);
      send_byte(8'h00); send_byte(8'hB0); send_byte(8'h07); send_byte(8'h64);
      send_byte(8'h00); send_byte(8'hD5); send_byte(8'h11);
      send_byte(8'h00); send_byte(8'hE9); send_byte(8'h00); send_byte(8'h40);
      send_mode(MODE_READ, 7'h7F);
      send_mode(MODE_READ, 7'h00);
   endtask

   task automatic test_meta_and_sysex();
      // tempo, time signature, short tempo, text, zero length, sysex, escape
      send_byte(8'h81); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h51);
      send_byte(8'h03); send_byte(8'h07); send_byte(8'hA1); send_byte(8'h20);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h58); send_byte(8'h05);
      for (int i = 0; i < 5; i++) send_byte(8'(4 + i));
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h51); send_byte(8'h01);
      send_byte(8'hAB);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h03); send_byte(8'h02);
      send_byte(8'h41); send_byte(8'h42);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'hF0); send_byte(8'h02); send_byte(8'h7E);
      send_byte(8'hF7);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
      send_byte(8'hF7); send_byte(8'h00);
   endtask

   task automatic test_errors();
      // overlong delta and length, running status, undefined system status
      for (int i = 0; i < 4; i++) send_byte(8'h80);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01);
      for (int i = 0; i < 4; i++) send_byte(8'hFF);
      send_byte(8'h00); send_byte(8'h40);
      send_byte(8'h00); send_byte(8'hF1);
      send_byte(8'h00); send_byte(8'hFE);
      send_mode(MODE_CLEAR, 7'h00);
      send_mode(MODE_READ, 7'h7F);
      send_mode(mode_type'(2'd3), 7'h55);
   endtask

   task automatic random_event();
      int sel;
      int len;
      logic [7:0] st;
      sel = $urandom_range(99);
      if (sel < 8) begin
         send_byte(8'($urandom));
         return;
      end else if (sel < 12) begin
         send_mode(MODE_READ, 7'($urandom));
         return;
      end else if (sel < 13) begin
         send_mode($urandom_range(1) ? MODE_CLEAR : mode_type'(2'd3), 7'($urandom));
         return;
      end
      random_delta();
      if (sel < 60) begin
         st = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
         send_byte(st);
         send_byte(8'($urandom));
         if (st[7:4] != CMD_PROGRAM && st[7:4] != CMD_PRESSURE) send_byte(8'($urandom));
      end else if (sel < 85) begin
         send_byte(ST_META);
         case ($urandom_range(4))
            0: st = MT_TEMPO;
            1: st = MT_TIMESIG;
            2: st = 8'($urandom_range(1, 7));
            default: st = 8'($urandom);
         endcase
         send_byte(st);
         len = $urandom_range(6);
         send_quantity(28'(len));
         for (int i = 0; i < len; i++) send_byte(8'($urandom));
      end else if (sel < 95) begin
         send_byte($urandom_range(1) ? ST_SYSEX : ST_ESCAPE);
         len = $urandom_range(5);
         send_quantity(28'(len));
         for (int i = 0; i < len; i++) send_byte(8'($urandom));
      end else begin
         send_byte({1'b1, 7'($urandom)});
      end
   endtask

   task automatic test_random_stream(int count);
      int target;
      target = requests_sent + count;
      while (requests_sent < target) random_event();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.mode = MODE_TRACK;
      req_if.data_byte = '0;
      req_if.patch_index = '0;
      errors = 0;
      results_seen = 0;
      requests_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 4; i++) cap_q[i] = '0;
      restart_parse();
      delta_q = '0;
      status_q = '0;
      mtype_q = '0;
      remain_q = '0;
      clear_patch_tables();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_channel_events();
      test_meta_and_sysex();
      test_errors();
      send_idle_pct = 15;
      recv_idle_pct = 62;
      test_random_stream(590);
      send_idle_pct = 62;
      recv_idle_pct = 15;
      test_random_stream(590);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(590);
      req_if.valid <= 1'b0;
      wait_drained();

      $display("covered %0d requests and %0d results: channel, meta, sysex, text,",
               requests_sent, results_seen);
      $display("length and status errors, patch reads and clears, with back-pressure");
      if (errors == 0) begin
         $display("midi_track_event_parser: match");
      end else begin
         $display("%0d mismatches", errors);
         $display("midi_track_event_parser: mismatch");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2ms;
      $display("timeout");
      $display("midi_track_event_parser: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
design/mtp_pkg.sv
design/mtp_if.sv
design/mtp_ram.sv
design/mtp_fifo.sv
design/mtp_front.sv
design/mtp_back.sv
design/midi_track_event_parser.sv
tb/mtp_tb_if.sv
tb/testbench.sv
